[design/vliru_pkg.sv]
// Shared types and constants for the value list insert/remove unit.
`default_nettype none

package vliru_pkg;

   localparam int MODE_W     = 2;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 6;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;

   typedef enum logic [MODE_W-1:0] {
      MODE_INS_FRONT = 2'd0,
      MODE_INS_BACK  = 2'd1,
      MODE_REMOVE    = 2'd2,
      MODE_READ      = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_BAD_INDEX = 2'd2
   } status_type;

   typedef struct packed {
      logic       ins_front;
      logic       ins_back;
      logic       read_issue;
      logic       scan_start;
      logic       scan_run;
      logic       scan_finish;
      logic       rsp_load;
      logic       rsp_removed;
      logic       rsp_rdata;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic bad_index;
      logic scan_done;
   } stat_type;

endpackage

`default_nettype wire

[design/vliru_if.sv]
// Request and response channel interfaces of the value list unit.
`default_nettype none

interface vliru_req_if;
   logic                                    valid;
   logic                                    ready;
   logic        [vliru_pkg::MODE_W-1:0]     mode;
   logic signed [vliru_pkg::VALUE_W-1:0]    value;
   logic        [vliru_pkg::POSITION_W-1:0] position;

   modport source (output valid, output mode, output value, output position, input ready);
   modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface vliru_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic        [vliru_pkg::STATUS_W-1:0] status;
   logic        [vliru_pkg::COUNT_W-1:0]  removed_count;
   logic        [vliru_pkg::COUNT_W-1:0]  item_count;
   logic signed [vliru_pkg::VALUE_W-1:0]  read_value;

   modport source (output valid, output status, output removed_count, output item_count,
                   output read_value, input ready);
   modport sink   (input valid, input status, input removed_count, input item_count,
                   input read_value, output ready);
endinterface

`default_nettype wire

[design/value_list_insert_remove_unit.sv]
// Top level of the value list unit: bounded double-ended list with remove-all-matching.
// Inserts and refused operations give their result in the cycle after the item is accepted.
// A read in range goes through a read wait state for the registered store read, then gives its result.
// Removal walks one entry per cycle and gives its result once the walk is done.
// One item is worked on at a time; the next is taken once the controller is idle and no result waits untaken.
// Reset empties the list and clears control state; the store itself is not cleared.
`default_nettype none

module value_list_insert_remove_unit #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input logic         clock,
   input logic         reset,
   vliru_req_if.sink   req_port,
   vliru_rsp_if.source rsp_port
);

   vliru_pkg::cmd_type  cmd;
   vliru_pkg::stat_type stat;

   vliru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .mode      (vliru_pkg::mode_type'(req_port.mode)),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   vliru_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .value         (req_port.value),
      .position      (req_port.position),
      .stat          (stat),
      .status        (rsp_port.status),
      .removed_count (rsp_port.removed_count),
      .item_count    (rsp_port.item_count),
      .read_value    (rsp_port.read_value)
   );

endmodule

`default_nettype wire

[design/vliru_ctrl.sv]
// Controller state machine sequencing inserts, reads and the removal walk.
`default_nettype none

module vliru_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  vliru_pkg::mode_type mode,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  vliru_pkg::stat_type stat,
   output vliru_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.rsp_status = vliru_pkg::STATUS_OK;
      state_in       = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (mode) inside
                  vliru_pkg::MODE_INS_FRONT, vliru_pkg::MODE_INS_BACK: begin
                     cmd.rsp_load = 1'b1;
                     if (stat.full) begin
                        cmd.rsp_status = vliru_pkg::STATUS_FULL;
                     end else begin
                        cmd.ins_front = (mode == vliru_pkg::MODE_INS_FRONT);
                        cmd.ins_back  = (mode == vliru_pkg::MODE_INS_BACK);
                     end
                  end
                  vliru_pkg::MODE_READ: begin
                     if (stat.bad_index) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = vliru_pkg::STATUS_BAD_INDEX;
                     end else begin
                        cmd.read_issue = 1'b1;
                        state_in       = ST_READ;
                     end
                  end
                  vliru_pkg::MODE_REMOVE: begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            cmd.rsp_load  = 1'b1;
            cmd.rsp_rdata = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               cmd.scan_finish = 1'b1;
               cmd.rsp_load    = 1'b1;
               cmd.rsp_removed = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // No finished item may be waiting while the store is being compacted.
   a_scan_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !rsp_valid_ff)
      else $error("result pending during removal walk");

   a_read_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> cmd.rsp_load)
      else $error("read wait state did not load a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.rsp_load)
      else $error("result register overwritten before being taken");
`endif

endmodule

`default_nettype wire

[design/vliru_datapath.sv]
// Datapath: ring store, front pointer, entry count, removal walk and result register.
`default_nettype none

module vliru_datapath #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  vliru_pkg::cmd_type                      cmd,
   input  logic signed [vliru_pkg::VALUE_W-1:0]    value,
   input  logic        [vliru_pkg::POSITION_W-1:0] position,
   output vliru_pkg::stat_type                     stat,
   output logic        [vliru_pkg::STATUS_W-1:0]   status,
   output logic        [vliru_pkg::COUNT_W-1:0]    removed_count,
   output logic        [vliru_pkg::COUNT_W-1:0]    item_count,
   output logic signed [vliru_pkg::VALUE_W-1:0]    read_value
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W > vliru_pkg::POSITION_W) ? CNT_W : vliru_pkg::POSITION_W;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [IDX_W-1:0]      front_ff, front_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]      left_ff, left_in;
   logic [CNT_W-1:0]      keep_ff, keep_in;
   logic [CNT_W-1:0]      removed_ff, removed_in;
   logic                  pend_ff, pend_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   vliru_pkg::status_type             status_ff;
   logic [vliru_pkg::COUNT_W-1:0]     removed_out_ff;
   logic [vliru_pkg::COUNT_W-1:0]     item_out_ff;
   logic [vliru_pkg::VALUE_W-1:0]     read_out_ff;

   logic [63:0]                  value_wide;
   logic [DATA_WIDTH-1:0]        in_word;
   logic signed [DATA_WIDTH-1:0] rd_signed;
   logic [63:0]                  rd_wide;
   logic [IDX_W-1:0]             front_dec;
   logic [CNT_W-1:0]             pos_off;
   logic                         match;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;

   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] ptr);
      logic [IDX_W-1:0] nxt;
      nxt = (ptr == IDX_W'(DEPTH - 1)) ? '0 : ptr + IDX_W'(1);
      return nxt;
   endfunction

   assign value_wide = 64'($unsigned(value));
   assign in_word    = value_wide[DATA_WIDTH-1:0];
   assign rd_signed  = rd_data_ff;
   assign rd_wide    = 64'(rd_signed);
   assign front_dec  = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);
   assign pos_off    = CNT_W'(position);
   assign match      = (rd_data_ff == key_ff);

   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.bad_index = (CMP_W'(position) >= CMP_W'(count_ff));
   assign stat.scan_done = (left_ff == '0) && !pend_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = front_dec;
      wr_data = in_word;
      if (cmd.ins_front) begin
         wr_en = 1'b1;
      end else if (cmd.ins_back) begin
         wr_en   = 1'b1;
         wr_addr = ring_add(front_ff, count_ff);
      end else if (cmd.scan_run && pend_ff && !match) begin
         wr_en   = 1'b1;
         wr_addr = wr_ptr_ff;
         wr_data = rd_data_ff;
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = rd_ptr_ff;
      if (cmd.read_issue) begin
         rd_en   = 1'b1;
         rd_addr = ring_add(front_ff, pos_off);
      end else if (cmd.scan_run && (left_ff != '0)) begin
         rd_en = 1'b1;
      end
   end

   always_comb begin
      front_in   = front_ff;
      count_in   = count_ff;
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      left_in    = left_ff;
      keep_in    = keep_ff;
      removed_in = removed_ff;
      pend_in    = pend_ff;
      key_in     = key_ff;
      if (cmd.ins_front) begin
         front_in = front_dec;
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.ins_back) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.scan_start) begin
         rd_ptr_in  = front_ff;
         wr_ptr_in  = front_ff;
         left_in    = count_ff;
         keep_in    = '0;
         removed_in = '0;
         pend_in    = 1'b0;
         key_in     = in_word;
      end
      if (cmd.scan_run) begin
         if (left_ff != '0) begin
            rd_ptr_in = ring_inc(rd_ptr_ff);
            left_in   = left_ff - CNT_W'(1);
            pend_in   = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff) begin
            if (match) begin
               removed_in = removed_ff + CNT_W'(1);
            end else begin
               wr_ptr_in = ring_inc(wr_ptr_ff);
               keep_in   = keep_ff + CNT_W'(1);
            end
         end
      end
      if (cmd.scan_finish) begin
         count_in = keep_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff   <= '0;
         count_ff   <= '0;
         left_ff    <= '0;
         keep_ff    <= '0;
         removed_ff <= '0;
         pend_ff    <= 1'b0;
      end else begin
         front_ff   <= front_in;
         count_ff   <= count_in;
         left_ff    <= left_in;
         keep_ff    <= keep_in;
         removed_ff <= removed_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      wr_ptr_ff <= wr_ptr_in;
      key_ff    <= key_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         status_ff      <= cmd.rsp_status;
         removed_out_ff <= cmd.rsp_removed ? vliru_pkg::COUNT_W'(removed_ff) : '0;
         item_out_ff    <= vliru_pkg::COUNT_W'(count_in);
         read_out_ff    <= cmd.rsp_rdata ? rd_wide[vliru_pkg::VALUE_W-1:0] : '0;
      end
   end

   assign status        = status_ff;
   assign removed_count = removed_out_ff;
   assign item_count    = item_out_ff;
   assign read_value    = read_out_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond store depth");

   // Every entry of the list is either still to be read, waiting, kept or removed.
   a_scan_balance: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_run |-> ((SUM_W'(left_ff) + SUM_W'(keep_ff) + SUM_W'(removed_ff)
                         + SUM_W'(pend_ff)) == SUM_W'(count_ff)))
      else $error("removal walk lost track of entries");
`endif

endmodule

`default_nettype wire

[verif/value_list_insert_remove_unit_test.sv]
// Self-checking testbench for the value list unit: directed table, then random traffic.
`default_nettype none

module value_list_insert_remove_unit_test;

   localparam int LIST_DEPTH   = 64;
   localparam int RANDOM_ITEMS = 700;
   localparam int CALM_TAIL    = 100;
   localparam int HOLD_AFTER   = 250;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 80;
   localparam int LIMIT_CYCLES = 400000;

   typedef struct packed {
      vliru_pkg::status_type         status;
      logic [vliru_pkg::COUNT_W-1:0] removed_count;
      logic [vliru_pkg::COUNT_W-1:0] item_count;
      logic [vliru_pkg::VALUE_W-1:0] read_value;
   } list_reply_type;

   typedef struct {
      vliru_pkg::mode_type              op;
      logic [vliru_pkg::VALUE_W-1:0]    value;
      logic [vliru_pkg::POSITION_W-1:0] position;
      int                               reps;
      bit                               typed;
      list_reply_type                   reply;
   } list_row_type;

   logic clock = 1'b0;
   logic reset;

   vliru_req_if req_ch ();
   vliru_rsp_if rsp_ch ();

   value_list_insert_remove_unit #(
      .DEPTH      (LIST_DEPTH),
      .DATA_WIDTH (vliru_pkg::VALUE_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   always #5 clock = ~clock;

   logic [vliru_pkg::VALUE_W-1:0]    shadow_entries [LIST_DEPTH];
   logic [vliru_pkg::POSITION_W-1:0] shadow_front = '0;
   logic [vliru_pkg::COUNT_W-1:0]    shadow_count = '0;

   list_reply_type                replies_due [$];
   list_row_type                  directed_rows [$];
   logic [vliru_pkg::VALUE_W-1:0] value_pool [6];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int items_sent     = 0;
   bit gaps_on        = 1'b1;
   bit wind_down      = 1'b0;
   bit hold_wanted    = 1'b0;
   bit hold_served    = 1'b0;

   function automatic logic [vliru_pkg::POSITION_W-1:0] ring_slot(
      logic [vliru_pkg::POSITION_W-1:0] offset);
      return shadow_front + offset;
   endfunction

   function automatic list_reply_type list_reply_for(vliru_pkg::mode_type op,
                                                     logic [vliru_pkg::VALUE_W-1:0] val,
                                                     logic [vliru_pkg::POSITION_W-1:0] pos);
      list_reply_type                r;
      logic [vliru_pkg::COUNT_W-1:0] kept;
      logic [vliru_pkg::VALUE_W-1:0] e;
      r = '{vliru_pkg::STATUS_OK, 7'd0, 7'd0, 32'd0};
      case (op) inside
         vliru_pkg::MODE_INS_FRONT, vliru_pkg::MODE_INS_BACK: begin
            if (shadow_count >= LIST_DEPTH) begin
               r.status = vliru_pkg::STATUS_FULL;
            end else if (op == vliru_pkg::MODE_INS_FRONT) begin
               shadow_front = shadow_front - 6'd1;
               shadow_entries[shadow_front] = val;
               shadow_count = shadow_count + 7'd1;
            end else begin
               shadow_entries[ring_slot(shadow_count[vliru_pkg::POSITION_W-1:0])] = val;
               shadow_count = shadow_count + 7'd1;
            end
         end
         vliru_pkg::MODE_REMOVE: begin
            kept = '0;
            for (int i = 0; i < shadow_count; i++) begin
               e = shadow_entries[ring_slot(6'(i))];
               if (e == val) begin
                  r.removed_count = r.removed_count + 7'd1;
               end else begin
                  shadow_entries[ring_slot(kept[vliru_pkg::POSITION_W-1:0])] = e;
                  kept = kept + 7'd1;
               end
            end
            shadow_count = kept;
         end
         default: begin
            if (pos >= shadow_count) begin
               r.status = vliru_pkg::STATUS_BAD_INDEX;
            end else begin
               r.read_value = shadow_entries[ring_slot(pos)];
            end
         end
      endcase
      r.item_count = shadow_count;
      return r;
   endfunction

   function automatic list_row_type make_row(vliru_pkg::mode_type op,
                                             logic [vliru_pkg::VALUE_W-1:0] val,
                                             logic [vliru_pkg::POSITION_W-1:0] pos, int reps,
                                             int typed, vliru_pkg::status_type st,
                                             int removed, int count,
                                             logic [vliru_pkg::VALUE_W-1:0] rd);
      list_row_type row;
      row.op       = op;
      row.value    = val;
      row.position = pos;
      row.reps     = reps;
      row.typed    = (typed != 0);
      row.reply    = '{st, 7'(removed), 7'(count), rd};
      return row;
   endfunction

   function automatic logic [vliru_pkg::VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 3) == 0) begin
         return $urandom;
      end
      return value_pool[$urandom_range(0, 5)];
   endfunction

   task automatic send_item(vliru_pkg::mode_type op, logic [vliru_pkg::VALUE_W-1:0] val,
                            logic [vliru_pkg::POSITION_W-1:0] pos, bit typed,
                            list_reply_type typed_reply);
      if (gaps_on && !wind_down && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.mode     <= op;
      req_ch.value    <= val;
      req_ch.position <= pos;
      do @(posedge clock); while (!req_ch.ready);
      if (typed) begin
         void'(list_reply_for(op, val, pos));
         replies_due.push_back(typed_reply);
      end else begin
         replies_due.push_back(list_reply_for(op, val, pos));
      end
      items_sent++;
      @(negedge clock);
   endtask

   initial begin : item_source
      int                            directed_end;
      int                            random_end;
      int                            burst;
      int                            n;
      logic [vliru_pkg::VALUE_W-1:0] val;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.mode     = '0;
      req_ch.value    = '0;
      req_ch.position = '0;
      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'hFFFF_FFFF;
      value_pool[2] = 32'h7FFF_FFFF;
      value_pool[3] = 32'h8000_0000;
      value_pool[4] = $urandom;
      value_pool[5] = $urandom;

      directed_rows.push_back(make_row(vliru_pkg::MODE_READ, 32'h0, 6'd0, 1, 1,
                                       vliru_pkg::STATUS_BAD_INDEX, 0, 0, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_REMOVE, 32'h0, 6'd0, 1, 1,
                                       vliru_pkg::STATUS_OK, 0, 0, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_INS_FRONT, 32'h7FFF_FFFF, 6'd0, 1, 1,
                                       vliru_pkg::STATUS_OK, 0, 1, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_INS_BACK, 32'h8000_0000, 6'd63, 1, 1,
                                       vliru_pkg::STATUS_OK, 0, 2, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_READ, 32'h0, 6'd0, 1, 1,
                                       vliru_pkg::STATUS_OK, 0, 2, 32'h7FFF_FFFF));
      directed_rows.push_back(make_row(vliru_pkg::MODE_READ, 32'h0, 6'd1, 1, 1,
                                       vliru_pkg::STATUS_OK, 0, 2, 32'h8000_0000));
      directed_rows.push_back(make_row(vliru_pkg::MODE_READ, 32'h0, 6'd2, 1, 1,
                                       vliru_pkg::STATUS_BAD_INDEX, 0, 2, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_READ, 32'hFFFF_FFFF, 6'd63, 1, 1,
                                       vliru_pkg::STATUS_BAD_INDEX, 0, 2, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_INS_BACK, 32'hFFFF_FFFF, 6'd0, 1, 1,
                                       vliru_pkg::STATUS_OK, 0, 3, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_INS_FRONT, 32'hFFFF_FFFF, 6'd0, 1, 1,
                                       vliru_pkg::STATUS_OK, 0, 4, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 6'd0, 1, 1,
                                       vliru_pkg::STATUS_OK, 2, 2, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_READ, 32'h0, 6'd1, 1, 1,
                                       vliru_pkg::STATUS_OK, 0, 2, 32'h8000_0000));
      directed_rows.push_back(make_row(vliru_pkg::MODE_REMOVE, 32'h1234_5678, 6'd0, 1, 1,
                                       vliru_pkg::STATUS_OK, 0, 2, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_INS_BACK, 32'd5, 6'd0, 62, 0,
                                       vliru_pkg::STATUS_OK, 0, 0, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_INS_FRONT, 32'h0, 6'd0, 1, 1,
                                       vliru_pkg::STATUS_FULL, 0, 64, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_INS_BACK, 32'h0, 6'd0, 1, 1,
                                       vliru_pkg::STATUS_FULL, 0, 64, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_READ, 32'h0, 6'd63, 1, 1,
                                       vliru_pkg::STATUS_OK, 0, 64, 32'd5));
      directed_rows.push_back(make_row(vliru_pkg::MODE_REMOVE, 32'd5, 6'd0, 1, 1,
                                       vliru_pkg::STATUS_OK, 62, 2, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_REMOVE, 32'h7FFF_FFFF, 6'd0, 1, 1,
                                       vliru_pkg::STATUS_OK, 1, 1, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_REMOVE, 32'h8000_0000, 6'd0, 1, 1,
                                       vliru_pkg::STATUS_OK, 1, 0, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_INS_FRONT, 32'h0, 6'd0, 64, 0,
                                       vliru_pkg::STATUS_OK, 0, 0, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_INS_BACK, 32'hFFFF_FFFF, 6'd63, 1, 1,
                                       vliru_pkg::STATUS_FULL, 0, 64, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_REMOVE, 32'h0, 6'd0, 1, 1,
                                       vliru_pkg::STATUS_OK, 64, 0, 0));
      directed_rows.push_back(make_row(vliru_pkg::MODE_READ, 32'hFFFF_FFFF, 6'd0, 1, 1,
                                       vliru_pkg::STATUS_BAD_INDEX, 0, 0, 0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         repeat (directed_rows[k].reps) begin
            send_item(directed_rows[k].op, directed_rows[k].value, directed_rows[k].position,
                      directed_rows[k].typed, directed_rows[k].reply);
         end
      end

      directed_end = items_sent;
      random_end   = directed_end + RANDOM_ITEMS;
      while (items_sent < random_end) begin
         if (items_sent >= random_end - CALM_TAIL) wind_down = 1'b1;
         if (!hold_wanted && items_sent >= directed_end + HOLD_AFTER) hold_wanted = 1'b1;
         gaps_on = ($urandom_range(0, 2) != 0);
         burst   = $urandom_range(0, 19);
         case (burst) inside
            0: begin
               n = LIST_DEPTH - shadow_count + $urandom_range(1, 3);
               repeat (n) begin
                  send_item(vliru_pkg::mode_type'($urandom_range(0, 1)), pick_value(),
                            6'($urandom), 1'b0, '0);
               end
            end
            [1:6]: begin
               repeat ($urandom_range(1, 8)) begin
                  send_item(vliru_pkg::mode_type'($urandom_range(0, 1)), pick_value(),
                            6'($urandom), 1'b0, '0);
               end
            end
            [7:10]: begin
               repeat ($urandom_range(1, 6)) begin
                  if (shadow_count != 0 && $urandom_range(0, 4) != 0) begin
                     n = $urandom_range(0, shadow_count - 1);
                  end else begin
                     n = $urandom_range(0, 63);
                  end
                  send_item(vliru_pkg::MODE_READ, $urandom, 6'(n), 1'b0, '0);
               end
            end
            [11:14]: begin
               if (shadow_count != 0 && $urandom_range(0, 1) == 0) begin
                  val = shadow_entries[ring_slot(6'($urandom_range(0, shadow_count - 1)))];
               end else begin
                  val = pick_value();
               end
               send_item(vliru_pkg::MODE_REMOVE, val, 6'($urandom), 1'b0, '0);
            end
            15: send_item(vliru_pkg::MODE_REMOVE, $urandom, 6'($urandom), 1'b0, '0);
            default: begin
               repeat ($urandom_range(1, 4)) begin
                  send_item(vliru_pkg::mode_type'($urandom_range(0, 3)), $urandom,
                            6'($urandom), 1'b0, '0);
               end
            end
         endcase
      end

      req_ch.valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : reply_sink
      int stall_left;
      int calm_left;
      stall_left   = 0;
      calm_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_wanted && !hold_served) begin
            hold_served = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (wind_down) begin
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (calm_left > 0) begin
            rsp_ch.ready <= 1'b1;
            calm_left--;
         end else begin
            case ($urandom_range(0, 5))
               0: begin
                  stall_left = $urandom_range(1, 13) - 1;
                  rsp_ch.ready <= 1'b0;
               end
               1: begin
                  calm_left = $urandom_range(20, 80);
                  rsp_ch.ready <= 1'b1;
               end
               default: rsp_ch.ready <= 1'b1;
            endcase
         end
      end
   end

   always @(posedge clock) begin : reply_check
      list_reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (replies_due.size() == 0) begin
            $display("%0t: item with none awaited: status %0d removed %0d count %0d read %h",
                     $time, rsp_ch.status, rsp_ch.removed_count, rsp_ch.item_count,
                     rsp_ch.read_value);
            mismatch_count++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_ch.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_ch.status);
               mismatch_count++;
            end
            if (rsp_ch.removed_count !== want.removed_count) begin
               $display("%0t: removed_count expected %0d actual %0d", $time,
                        want.removed_count, rsp_ch.removed_count);
               mismatch_count++;
            end
            if (rsp_ch.item_count !== want.item_count) begin
               $display("%0t: item_count expected %0d actual %0d", $time, want.item_count,
                        rsp_ch.item_count);
               mismatch_count++;
            end
            if (rsp_ch.read_value !== want.read_value) begin
               $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                        rsp_ch.read_value);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule

`default_nettype wire

[filelist.f]
design/vliru_pkg.sv
design/vliru_if.sv
design/vliru_ctrl.sv
design/vliru_datapath.sv
design/value_list_insert_remove_unit.sv
verif/value_list_insert_remove_unit_test.sv
